// ----- src/atrd_pkg.sv -----
package atrd_pkg;

    // Response store geometry
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Transaction kinds
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Outcome codes
    localparam logic [1:0] OUTCOME_OK    = 2'd0;
    localparam logic [1:0] OUTCOME_ERROR = 2'd1;
    localparam logic [1:0] OUTCOME_FAIL  = 2'd2;

    // Terminator characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_O  = 8'h4F;
    localparam logic [7:0] CHAR_K  = 8'h4B;
    localparam logic [7:0] CHAR_E  = 8'h45;
    localparam logic [7:0] CHAR_R  = 8'h52;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_value;
        logic [15:0] timeout_ms;
        logic [11:0] read_index;
    } t_item;

    typedef struct packed {
        logic        armed;
        logic [1:0]  outcome;
        logic [12:0] received_count;
        logic [7:0]  read_byte;
    } t_result;

endpackage

// ----- src/atrd_ram.sv -----
module atrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/atrd_queue.sv -----
module atrd_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  atrd_pkg::t_result        i_data,
    output logic [atrd_pkg::QCNT_W-1:0] o_level,
    output logic                     o_empty,
    input  logic                     i_pop,
    output atrd_pkg::t_result        o_data
);
    import atrd_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wp;
    logic [QPTR_W-1:0]   n_rp;
    logic [QCNT_W-1:0]   n_count;
    logic                pop_ok;

    assign o_empty = (r_count == '0);
    assign o_level = r_count;
    assign o_data  = r_mem[r_rp];
    assign pop_ok  = i_pop && !o_empty;

    // Advance pointers and level
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = r_wp + QPTR_W'(1);
        end
        if (pop_ok) begin
            n_rp = r_rp + QPTR_W'(1);
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && pop_ok) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Hold result entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("result queue overflow");
    a_level_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop_ok) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("result queue level did not advance on push");
`endif

endmodule

// ----- src/atrd_front.sv -----
module atrd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  atrd_pkg::t_item             i_item,
    input  logic [atrd_pkg::QCNT_W-1:0] i_q_level,
    output logic                        o_q_push,
    output atrd_pkg::t_result           o_q_data
);
    import atrd_pkg::*;

    // Control state
    logic [LEN_W-1:0] r_len;
    logic             r_armed;
    logic [1:0]       r_code;
    logic [15:0]      r_time;
    logic [7:0]       r_recent [6];   // index 0 is the newest stored byte

    logic [LEN_W-1:0] n_len;
    logic             n_armed;
    logic [1:0]       n_code;
    logic [15:0]      n_time;
    logic [7:0]       n_recent [6];

    // Stage register carrying the status while the store read completes
    logic             r_s1_valid;
    t_result          r_s1_res;
    logic             r_s1_hit;

    logic             accept;
    logic             wr_en;
    logic             rd_hit;
    logic [LEN_W-1:0] new_len;
    logic             line_end;
    logic             ok_end;
    logic             err_end;
    logic [QCNT_W-1:0] level_sum;
    logic [7:0]       ram_q;

    // Hold off when the queue cannot absorb the transaction in flight
    assign level_sum = i_q_level + QCNT_W'(r_s1_valid);
    assign o_full    = (level_sum >= QCNT_W'(QUEUE_DEPTH));
    assign accept    = i_push && !o_full;

    // Classify a received byte against the recent history
    assign wr_en    = accept && (i_item.mode == MODE_BYTE) && r_armed
                      && (r_len < LEN_W'(STORE_DEPTH));
    assign new_len  = r_len + LEN_W'(1);
    assign line_end = (i_item.byte_value == CHAR_LF) && (new_len >= LEN_W'(2))
                      && (r_recent[0] == CHAR_CR);
    assign ok_end   = line_end && (new_len >= LEN_W'(4))
                      && (r_recent[2] == CHAR_O) && (r_recent[1] == CHAR_K);
    assign err_end  = line_end && (new_len >= LEN_W'(7))
                      && (r_recent[5] == CHAR_E) && (r_recent[4] == CHAR_R)
                      && (r_recent[3] == CHAR_R) && (r_recent[2] == CHAR_O)
                      && (r_recent[1] == CHAR_R);
    assign rd_hit   = (i_item.mode == MODE_READ)
                      && (LEN_W'(i_item.read_index) < r_len);

    // Next control state
    always_comb begin
        n_len    = r_len;
        n_armed  = r_armed;
        n_code   = r_code;
        n_time   = r_time;
        n_recent = r_recent;
        if (accept) begin
            unique case (i_item.mode)
                MODE_START: begin
                    n_len   = '0;
                    n_code  = OUTCOME_FAIL;
                    n_time  = i_item.timeout_ms;
                    n_armed = (i_item.timeout_ms != 16'd0);
                    for (int k = 0; k < 6; k++) begin
                        n_recent[k] = 8'd0;
                    end
                end
                MODE_BYTE: begin
                    if (r_armed) begin
                        if (!wr_en) begin
                            // store full: drop the byte
                            n_code  = OUTCOME_FAIL;
                            n_armed = 1'b0;
                        end else begin
                            n_len       = new_len;
                            n_recent[0] = i_item.byte_value;
                            for (int k = 1; k < 6; k++) begin
                                n_recent[k] = r_recent[k-1];
                            end
                            if (ok_end) begin
                                n_code  = OUTCOME_OK;
                                n_armed = 1'b0;
                            end else if (err_end) begin
                                n_code  = OUTCOME_ERROR;
                                n_armed = 1'b0;
                            end
                        end
                    end
                end
                MODE_TICK: begin
                    if (r_armed && (r_time != 16'd0)) begin
                        n_time = r_time - 16'd1;
                        if (r_time == 16'd1) begin
                            n_armed = 1'b0;
                        end
                    end
                end
                MODE_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_armed    <= 1'b0;
            r_code     <= OUTCOME_FAIL;
            r_time     <= 16'd0;
            r_s1_valid <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_recent[k] <= 8'd0;
            end
        end else begin
            r_len      <= n_len;
            r_armed    <= n_armed;
            r_code     <= n_code;
            r_time     <= n_time;
            r_recent   <= n_recent;
            r_s1_valid <= accept;
        end
    end

    // Capture the status of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res.armed          <= n_armed;
            r_s1_res.outcome        <= n_code;
            r_s1_res.received_count <= n_len;
            r_s1_res.read_byte      <= 8'd0;
            r_s1_hit                <= rd_hit;
        end
    end

    atrd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data (i_item.byte_value),
        .i_rd_addr (ADDR_W'(i_item.read_index)),
        .o_rd_data (ram_q)
    );

    // Merge the store data and hand the result to the queue
    always_comb begin
        o_q_data = r_s1_res;
        o_q_data.read_byte = r_s1_hit ? ram_q : 8'd0;
    end
    assign o_q_push = r_s1_valid;

`ifndef SYNTHESIS
    a_armed_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_time != 16'd0))
        else $error("armed with no time left");
    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(STORE_DEPTH))
        else $error("stored length beyond store depth");
    a_zero_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.mode == MODE_START) && (i_item.timeout_ms == 16'd0))
        |=> (!r_armed && (r_code == OUTCOME_FAIL) && (r_len == '0)))
        else $error("start with zero timeout left the block armed");
`endif

endmodule

// ----- src/at_response_terminator_detector.sv -----
// AT response terminator detector. Every transaction (start, received byte,
// millisecond tick, read) yields exactly one result in order: armed flag,
// outcome (ok, error, fail), stored byte count, and for reads the stored
// byte or 0 past the count. One transaction is taken per clock while full is
// low; its result is held in a stage register beside the registered store read,
// then enters the internal 4-entry result queue and shows on the result ports,
// from which it can be popped. Full rises only when that queue plus the
// transaction in flight fill it. The stage register waits on the registered
// read of the 4096-byte response store, which takes one write and one read per
// cycle. The store needs no clearing after reset: only bytes written since the
// last start are ever read back.
module at_response_terminator_detector (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  atrd_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output atrd_pkg::t_result o_result
);
    import atrd_pkg::*;

    logic [QCNT_W-1:0] q_level;
    logic              q_push;
    t_result           q_data;

    atrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .i_q_level (q_level),
        .o_q_push  (q_push),
        .o_q_data  (q_data)
    );

    atrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .o_level (q_level),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_result)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import atrd_pkg::*;

    localparam int N_DIRECTED     = 28;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam bit TYPED          = 1'b1;
    localparam bit PRED           = 1'b0;

    // One row of the directed table: transaction plus an optional typed-in result
    typedef struct packed {
        t_item   item;
        logic    typed;
        t_result want;
    } t_dir_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_item   i_item;
    logic    empty;
    logic    pop;
    t_result o_result;

    // Shadow copy of the detector state
    logic [7:0]  rsp_mem [STORE_DEPTH];
    int          rsp_len;
    logic        capturing;
    logic [1:0]  rsp_code;
    logic [15:0] ms_left;
    logic [7:0]  tail [7];

    t_result  pending_results [$];
    t_result  want_r;
    t_dir_row dir_rows [N_DIRECTED];

    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    int n_fail        = 0;
    int n_items       = 0;
    int n_effective   = 0;
    int n_results     = 0;
    int n_full_stalls = 0;
    int n_end_ok      = 0;
    int n_end_err     = 0;
    int n_end_fail    = 0;
    int max_len       = 0;
    int quiet_cycles  = 0;

    at_response_terminator_detector u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Advance the shadow state by one transaction and return its result
    function automatic t_result predict_response(input t_item it);
        t_result r;
        int      k;
        r = '0;
        case (it.mode)
            MODE_START: begin
                rsp_len   = 0;
                rsp_code  = OUTCOME_FAIL;
                ms_left   = it.timeout_ms;
                capturing = (it.timeout_ms != 16'd0);
                for (k = 0; k < 7; k++) tail[k] = 8'h00;
            end
            MODE_BYTE: begin
                if (capturing && rsp_len >= STORE_DEPTH) begin
                    // store full: drop the byte and give up on this response
                    rsp_code  = OUTCOME_FAIL;
                    capturing = 1'b0;
                end else if (capturing) begin
                    rsp_mem[rsp_len] = it.byte_value;
                    rsp_len++;
                    for (k = 6; k > 0; k--) tail[k] = tail[k - 1];
                    tail[0] = it.byte_value;
                    // a line feed after a carriage return may close the response
                    if (tail[0] == CHAR_LF && rsp_len >= 2 && tail[1] == CHAR_CR) begin
                        if (rsp_len >= 4 && tail[3] == CHAR_O && tail[2] == CHAR_K) begin
                            rsp_code  = OUTCOME_OK;
                            capturing = 1'b0;
                        end else if (rsp_len >= 7 && tail[6] == CHAR_E &&
                                     tail[5] == CHAR_R && tail[4] == CHAR_R &&
                                     tail[3] == CHAR_O && tail[2] == CHAR_R) begin
                            rsp_code  = OUTCOME_ERROR;
                            capturing = 1'b0;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (capturing && ms_left != 16'd0) begin
                    ms_left = ms_left - 16'd1;
                    if (ms_left == 16'd0) capturing = 1'b0;
                end
            end
            default: begin
                if (int'(it.read_index) < rsp_len) r.read_byte = rsp_mem[it.read_index];
            end
        endcase
        r.armed          = capturing;
        r.outcome        = rsp_code;
        r.received_count = rsp_len[12:0];
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [1:0] mode, input logic [7:0] b,
                                        input logic [15:0] tmo, input logic [11:0] idx,
                                        input bit typed, input logic armed,
                                        input logic [1:0] oc, input logic [12:0] cnt);
        t_dir_row row;
        row.item  = '{mode: mode, byte_value: b, timeout_ms: tmo, read_index: idx};
        row.typed = typed;
        row.want  = '{armed: armed, outcome: oc, received_count: cnt, read_byte: 8'h00};
        return row;
    endfunction

    function automatic t_item any_item();
        t_item it;
        it.mode       = 2'($urandom);
        it.byte_value = 8'($urandom);
        it.timeout_ms = 16'($urandom);
        it.read_index = 12'($urandom);
        return it;
    endfunction

    // Favor terminator characters so that endings and near misses are common
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return CHAR_CR;
            1:       return CHAR_LF;
            2:       return CHAR_O;
            3:       return CHAR_K;
            4:       return CHAR_E;
            5:       return CHAR_R;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly indexes around the stored count, sometimes anywhere
    function automatic logic [15:0] read_pick();
        int top;
        top = (rsp_len + 1 > 4095) ? 4095 : rsp_len + 1;
        if ($urandom_range(0, 5) == 0) return 16'($urandom);
        return 16'($urandom_range(0, top));
    endfunction

    function automatic int unsigned tx_gap();
        return tx_quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // Offer one transaction, hold it until taken, then log its expected result
    task automatic drive_item(input t_item it, input int unsigned gap, input bit typed,
                              input t_result want);
        t_result r;
        bit      was_armed;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        was_armed = capturing;
        n_items++;
        if (!((it.mode == MODE_BYTE || it.mode == MODE_TICK) && !capturing)) n_effective++;
        r = predict_response(it);
        pending_results.push_back(typed ? want : r);
        if (rsp_len > max_len) max_len = rsp_len;
        if (was_armed && !capturing && it.mode != MODE_START) begin
            case (rsp_code)
                OUTCOME_OK:    n_end_ok++;
                OUTCOME_ERROR: n_end_err++;
                default:       n_end_fail++;
            endcase
        end
    endtask

    task automatic offer(input logic [1:0] mode, input logic [15:0] value);
        t_item it;
        it      = any_item();
        it.mode = mode;
        case (mode)
            MODE_START: it.timeout_ms = value;
            MODE_BYTE:  it.byte_value = value[7:0];
            MODE_READ:  it.read_index = value[11:0];
            default:    ;
        endcase
        drive_item(it, tx_gap(), 1'b0, '0);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) offer(MODE_BYTE, {8'h00, s[k]});
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: reset, directed table, random responses
    initial begin
        int          k;
        int          n;
        int          seq;
        logic [15:0] tmo;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_item    <= '0;
        rsp_len   = 0;
        capturing = 1'b0;
        rsp_code  = OUTCOME_FAIL;
        ms_left   = 16'd0;
        for (k = 0; k < 7; k++) tail[k] = 8'h00;

        dir_rows[0]  = mk_row(MODE_READ,  8'h00,   16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_FAIL,  13'd0);
        dir_rows[1]  = mk_row(MODE_TICK,  8'h00,   16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_FAIL,  13'd0);
        dir_rows[2]  = mk_row(MODE_BYTE,  8'hFF,   16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_FAIL,  13'd0);
        dir_rows[3]  = mk_row(MODE_START, 8'h00,   16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_FAIL,  13'd0);
        dir_rows[4]  = mk_row(MODE_START, 8'h00,   16'hFFFF, 12'h000, TYPED, 1'b1, OUTCOME_FAIL,  13'd0);
        dir_rows[5]  = mk_row(MODE_BYTE,  CHAR_LF, 16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[6]  = mk_row(MODE_BYTE,  CHAR_CR, 16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[7]  = mk_row(MODE_BYTE,  CHAR_LF, 16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[8]  = mk_row(MODE_BYTE,  CHAR_O,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[9]  = mk_row(MODE_BYTE,  CHAR_K,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[10] = mk_row(MODE_BYTE,  CHAR_CR, 16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[11] = mk_row(MODE_BYTE,  CHAR_LF, 16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_OK,    13'd7);
        dir_rows[12] = mk_row(MODE_READ,  8'h00,   16'h0000, 12'h003, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[13] = mk_row(MODE_READ,  8'h00,   16'h0000, 12'hFFF, TYPED, 1'b0, OUTCOME_OK,    13'd7);
        dir_rows[14] = mk_row(MODE_START, 8'h00,   16'h0002, 12'h000, TYPED, 1'b1, OUTCOME_FAIL,  13'd0);
        dir_rows[15] = mk_row(MODE_TICK,  8'h00,   16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[16] = mk_row(MODE_BYTE,  CHAR_E,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[17] = mk_row(MODE_BYTE,  CHAR_R,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[18] = mk_row(MODE_BYTE,  CHAR_R,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[19] = mk_row(MODE_BYTE,  CHAR_O,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[20] = mk_row(MODE_BYTE,  CHAR_R,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[21] = mk_row(MODE_BYTE,  CHAR_CR, 16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[22] = mk_row(MODE_BYTE,  CHAR_LF, 16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_ERROR, 13'd7);
        dir_rows[23] = mk_row(MODE_START, 8'h00,   16'h0001, 12'h000, TYPED, 1'b1, OUTCOME_FAIL,  13'd0);
        dir_rows[24] = mk_row(MODE_TICK,  8'h00,   16'h0000, 12'h000, TYPED, 1'b0, OUTCOME_FAIL,  13'd0);
        dir_rows[25] = mk_row(MODE_START, 8'h00,   16'h0003, 12'h000, TYPED, 1'b1, OUTCOME_FAIL,  13'd0);
        dir_rows[26] = mk_row(MODE_BYTE,  CHAR_K,  16'h0000, 12'h000, PRED,  1'b0, OUTCOME_OK,    13'd0);
        dir_rows[27] = mk_row(MODE_START, 8'h00,   16'h0005, 12'h000, TYPED, 1'b1, OUTCOME_FAIL,  13'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (k = 0; k < N_DIRECTED; k++)
            drive_item(dir_rows[k].item, tx_gap(), dir_rows[k].typed, dir_rows[k].want);

        // Random responses, with noise and two pressure events
        seq = 0;
        while (n_items < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if (seq == 8) begin
                // stall the reader while reads keep coming
                rx_hold_req = 1'b1;
                tx_quiet    = 1'b1;
                for (k = 0; k < 24; k++) offer(MODE_READ, read_pick());
            end else if (seq == 20) begin
                pause_until_drained();
            end else if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(3, 8);
                for (k = 0; k < n; k++) drive_item(any_item(), tx_gap(), 1'b0, '0);
            end else begin
                case ($urandom_range(0, 9))
                    0:       tmo = 16'd0;
                    1, 2:    tmo = 16'($urandom_range(1, 4));
                    3:       tmo = 16'($urandom);
                    default: tmo = 16'($urandom_range(5, 60));
                endcase
                offer(MODE_START, tmo);
                n = $urandom_range(0, 20);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(0, 7))
                        0:       offer(MODE_TICK, 16'h0000);
                        1:       offer(MODE_READ, read_pick());
                        default: offer(MODE_BYTE, {8'h00, pick_byte()});
                    endcase
                end
                case ($urandom_range(0, 4))
                    0, 1:    send_text("OK\r\n");
                    2:       send_text("ERROR\r\n");
                    3:       send_text("ERR\r\n");
                    default: ;
                endcase
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) offer(MODE_READ, read_pick());
            end
            seq++;
        end

        pause_until_drained();
        $display("Sent %0d transactions, checked %0d results, input stalled %0d cycles",
                 n_items, n_results, n_full_stalls);
        $display("Responses closed: %0d ok, %0d error, %0d fail; longest %0d bytes",
                 n_end_ok, n_end_err, n_end_fail, max_len);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures", n_fail);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: random pop gaps, one long hold-off on request
    initial begin
        int unsigned w;
        int          hold_cnt;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req) begin
                pop <= 1'b0;
                for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            w = rx_quiet ? 0 : $urandom_range(0, 13);
            if (w != 0) begin
                pop <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    // Check each popped result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (push && full) n_full_stalls <= n_full_stalls + 1;
            if (pop && !empty) begin
                n_results <= n_results + 1;
                if (pending_results.size() == 0) begin
                    if (n_fail < 10)
                        $display("%0t: result with nothing outstanding: armed=%0d outcome=%0d",
                                 $time, o_result.armed, o_result.outcome);
                    n_fail++;
                end else begin
                    want_r = pending_results.pop_front();
                    if (o_result.armed !== want_r.armed ||
                        o_result.outcome !== want_r.outcome ||
                        o_result.received_count !== want_r.received_count ||
                        o_result.read_byte !== want_r.read_byte) begin
                        if (n_fail < 10)
                            $display({"%0t: mismatch armed %0d/%0d outcome %0d/%0d ",
                                      "count %0d/%0d byte %02h/%02h (expected/actual)"},
                                     $time, want_r.armed, o_result.armed,
                                     want_r.outcome, o_result.outcome,
                                     want_r.received_count, o_result.received_count,
                                     want_r.read_byte, o_result.read_byte);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/atrd_pkg.sv
src/atrd_ram.sv
src/atrd_queue.sv
src/atrd_front.sv
src/at_response_terminator_detector.sv
tb/testbench.sv
